@@ hw/rtl/pbo_pkg.sv @@
// ----------------------------------------------------------------------------
// pbo_pkg
// Shared types, codes and helpers for the polyline border offset unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pbo_pkg;

  localparam int CoordW   = 32;
  localparam int WidthW   = 24;
  localparam int IndexW   = 16;
  localparam int StatusW  = 2;
  localparam int CfgIdxW  = 8;
  localparam int InDataW  = 96;
  localparam int OutDataW = 176;

  localparam logic [IndexW-1:0] MaxIndex = 16'hFFFF;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_BORDER_WIDTH = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_CLOSED_LOOP  = 8'd1;

  localparam logic [WidthW-1:0] BorderWidthReset = 24'd1280;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_DEGEN = 2'd1;
  localparam logic [StatusW-1:0] ST_SHORT = 2'd2;

  typedef logic signed [CoordW-1:0] coord_t;

  // clamp a 34-bit signed sum to the 32-bit range
  function automatic coord_t sat32(input logic signed [33:0] v);
    coord_t r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/polyline_border_offset_unit.sv @@
// ----------------------------------------------------------------------------
// polyline_border_offset_unit
// Left and right border points of a streamed 3-D path, offset along the
// horizontal unit normal taken from the central difference of neighbors.
// ----------------------------------------------------------------------------
// Each point is taken in one transfer; the block then works alone until its
// results have left. A point gives zero to three results. One result passes
// through a load step, one-bit normalize shifts and a final check, squaring
// of both components, the bit-serial square root, two passes of the
// restoring divider, forming of the saturated borders and the output state.
// A stalled result waits in the output state while m_tready stays low. The
// squares and the width products share one multiplier. A degenerate result
// skips the arithmetic and goes from the load step straight to forming the
// borders. Each point is accepted in idle, and every point but the first
// ends with a bookkeeping step after its results.
`default_nettype none

module polyline_border_offset_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pbo_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [pbo_pkg::WidthW-1:0]    cfg_data,
  // point stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [pbo_pkg::InDataW-1:0]   s_tdata,   // pos_x, pos_y, pos_z
  input  wire logic                          s_tlast,   // last_point
  // result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [pbo_pkg::OutDataW-1:0]       m_tdata,   // point_index, left_x,
                                                        // left_z, right_x,
                                                        // right_z, height
  output logic [pbo_pkg::StatusW-1:0]        m_tuser,   // status
  output logic                               m_tlast    // last_result
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_SQ1  = 4'd3;
  localparam logic [3:0] S_SQ2  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_DINI = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FORM = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  localparam logic [1:0] J_PREV  = 2'd0;  // previous point, next one now known
  localparam logic [1:0] J_LAST  = 2'd1;  // final point
  localparam logic [1:0] J_FIRST = 2'd2;  // point 0 of a closed path
  localparam logic [1:0] J_SHORT = 2'd3;  // too-short status

  logic [3:0] state;
  logic [1:0] job;

  logic [pbo_pkg::WidthW-1:0] border_width;
  logic                       closed_loop;

  pbo_pkg::coord_t first_x, first_z, first_h, second_x, second_z;
  pbo_pkg::coord_t older_x, older_z, recent_x, recent_z, recent_h;
  logic [pbo_pkg::IndexW-1:0] point_count;

  pbo_pkg::coord_t cur_x, cur_y, cur_z;
  logic cur_last, cur_closed;

  // per-result working registers
  logic [pbo_pkg::IndexW-1:0] e_idx;
  pbo_pkg::coord_t e_cx, e_cz, e_h;
  logic e_last, e_dx_neg, e_dz_neg;
  logic [pbo_pkg::StatusW-1:0] e_status;
  logic [32:0] nx, nz;
  logic [63:0] acc, root, sbit;
  logic [4:0]  cnt;
  logic [30:0] len;
  logic [53:0] prod;
  logic [31:0] rem;
  logic [24:0] qsh, quo, mx, mz;
  logic        dsel;

  // output registers
  logic [pbo_pkg::IndexW-1:0] o_idx;
  pbo_pkg::coord_t o_lx, o_lz, o_rx, o_rz, o_h;
  logic [pbo_pkg::StatusW-1:0] o_status;
  logic o_last;

  pbo_pkg::coord_t in_x, in_y, in_z;
  assign in_x = s_tdata[31:0];
  assign in_y = s_tdata[63:32];
  assign in_z = s_tdata[95:64];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata   = {o_h, o_rz, o_rx, o_lz, o_lx, o_idx};
  assign m_tuser   = o_status;
  assign m_tlast   = o_last;

  // job selection
  logic [pbo_pkg::IndexW-1:0] j_idx;
  pbo_pkg::coord_t j_cx, j_cz, j_h, j_px, j_pz, j_nx, j_nz;
  logic j_last;

  always_comb begin
    j_idx  = point_count - 16'd1;
    j_cx   = recent_x;
    j_cz   = recent_z;
    j_h    = recent_h;
    j_px   = older_x;
    j_pz   = older_z;
    j_nx   = cur_x;
    j_nz   = cur_z;
    j_last = 1'b0;
    unique case (job)
      J_PREV: begin
      end
      J_LAST: begin
        j_idx  = point_count;
        j_cx   = cur_x;
        j_cz   = cur_z;
        j_h    = cur_y;
        j_px   = recent_x;
        j_pz   = recent_z;
        j_nx   = cur_closed ? first_x : cur_x;
        j_nz   = cur_closed ? first_z : cur_z;
        j_last = !cur_closed;
      end
      J_FIRST: begin
        j_idx  = '0;
        j_cx   = first_x;
        j_cz   = first_z;
        j_h    = first_h;
        j_px   = cur_x;
        j_pz   = cur_z;
        j_nx   = second_x;
        j_nz   = second_z;
        j_last = 1'b1;
      end
      J_SHORT: begin
      end
    endcase
  end

  logic signed [32:0] j_dx, j_dz;
  logic [32:0] j_ux, j_uz;
  assign j_dx = {j_nx[31], j_nx} - {j_px[31], j_px};
  assign j_dz = {j_nz[31], j_nz} - {j_pz[31], j_pz};
  assign j_ux = j_dx[32] ? 33'(-j_dx) : j_dx;
  assign j_uz = j_dz[32] ? 33'(-j_dz) : j_dz;

  logic [32:0] nmax;
  assign nmax = (nx > nz) ? nx : nz;

  // shared multiplier: squares, then the width products
  logic [29:0] mul_a, mul_b;
  logic [59:0] mul_p;

  always_comb begin
    mul_a = nx[29:0];
    mul_b = nx[29:0];
    if (state == S_SQ2) begin
      mul_a = nz[29:0];
      mul_b = nz[29:0];
    end else if (state == S_MUL) begin
      mul_a = dsel ? nx[29:0] : nz[29:0];
      mul_b = {6'b0, border_width};
    end
  end

  assign mul_p = mul_a * mul_b;

  // square root step
  logic [63:0] sq_try;
  assign sq_try = root + sbit;

  // divider step and numerator
  logic [56:0] num;
  logic [32:0] dtry;
  logic [31:0] dden;
  logic        dbit;
  logic [24:0] qfin;
  assign num  = {2'b0, prod, 1'b0} + {26'b0, len};
  assign dden = {len, 1'b0};
  assign dtry = {rem, qsh[24]};
  assign dbit = (dtry >= {1'b0, dden});
  assign qfin = {quo[23:0], dbit};

  logic signed [33:0] oxs, ozs;
  assign oxs = e_dz_neg ? -$signed({9'b0, mx}) : $signed({9'b0, mx});
  assign ozs = e_dx_neg ? -$signed({9'b0, mz}) : $signed({9'b0, mz});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      job          <= J_PREV;
      border_width <= pbo_pkg::BorderWidthReset;
      closed_loop  <= 1'b1;
      first_x      <= '0;
      first_z      <= '0;
      first_h      <= '0;
      second_x     <= '0;
      second_z     <= '0;
      older_x      <= '0;
      older_z      <= '0;
      recent_x     <= '0;
      recent_z     <= '0;
      recent_h     <= '0;
      point_count  <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == pbo_pkg::REG_BORDER_WIDTH) begin
          border_width <= cfg_data;
        end else if (cfg_index == pbo_pkg::REG_CLOSED_LOOP) begin
          closed_loop <= cfg_data[0];
        end
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cur_x      <= in_x;
            cur_y      <= in_y;
            cur_z      <= in_z;
            cur_last   <= s_tlast;
            cur_closed <= closed_loop;
            if (point_count == '0) begin
              if (s_tlast) begin
                o_idx    <= '0;
                o_lx     <= '0;
                o_lz     <= '0;
                o_rx     <= '0;
                o_rz     <= '0;
                o_h      <= '0;
                o_status <= pbo_pkg::ST_SHORT;
                o_last   <= 1'b1;
                job      <= J_SHORT;
                state    <= S_OUT;
              end else begin
                first_x     <= in_x;
                first_z     <= in_z;
                first_h     <= in_y;
                older_x     <= in_x;
                older_z     <= in_z;
                recent_x    <= in_x;
                recent_z    <= in_z;
                recent_h    <= in_y;
                point_count <= 16'd1;
              end
            end else begin
              if (point_count == 16'd1) begin
                second_x <= in_x;
                second_z <= in_z;
              end
              if (point_count != 16'd1 || !closed_loop) begin
                job   <= J_PREV;
                state <= S_LOAD;
              end else if (s_tlast) begin
                job   <= J_LAST;
                state <= S_LOAD;
              end else begin
                state <= S_FIN;
              end
            end
          end
        end
        S_LOAD: begin
          e_idx    <= j_idx;
          e_cx     <= j_cx;
          e_cz     <= j_cz;
          e_h      <= j_h;
          e_last   <= j_last;
          e_dx_neg <= j_dx[32];
          e_dz_neg <= j_dz[32];
          nx       <= j_ux;
          nz       <= j_uz;
          dsel     <= 1'b0;
          if (j_ux == '0 && j_uz == '0) begin
            e_status <= pbo_pkg::ST_DEGEN;
            mx       <= '0;
            mz       <= '0;
            state    <= S_FORM;
          end else begin
            e_status <= pbo_pkg::ST_OK;
            state    <= S_NORM;
          end
        end
        S_NORM: begin
          // bring the larger magnitude into [2^29, 2^30)
          if (nmax[32:30] != 3'b0) begin
            nx <= nx >> 1;
            nz <= nz >> 1;
          end else if (!nmax[29]) begin
            nx <= nx << 1;
            nz <= nz << 1;
          end else begin
            state <= S_SQ1;
          end
        end
        S_SQ1: begin
          acc   <= {4'b0, mul_p};
          state <= S_SQ2;
        end
        S_SQ2: begin
          acc   <= acc + {4'b0, mul_p};
          root  <= '0;
          sbit  <= 64'h4000_0000_0000_0000;
          cnt   <= 5'd31;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (acc >= sq_try) begin
            acc  <= acc - sq_try;
            root <= (root >> 1) + sbit;
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= cnt - 5'd1;
          if (cnt == '0) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          len   <= root[30:0];
          prod  <= mul_p[53:0];
          state <= S_DINI;
        end
        S_DINI: begin
          rem   <= num[56:25];
          qsh   <= num[24:0];
          quo   <= '0;
          cnt   <= 5'd24;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= dbit ? 32'(dtry - {1'b0, dden}) : dtry[31:0];
          qsh <= qsh << 1;
          quo <= qfin;
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            if (!dsel) begin
              mx    <= qfin;
              dsel  <= 1'b1;
              state <= S_MUL;
            end else begin
              mz    <= qfin;
              state <= S_FORM;
            end
          end
        end
        S_FORM: begin
          o_idx    <= e_idx;
          o_lx     <= pbo_pkg::sat32({{2{e_cx[31]}}, e_cx} - oxs);
          o_lz     <= pbo_pkg::sat32({{2{e_cz[31]}}, e_cz} + ozs);
          o_rx     <= pbo_pkg::sat32({{2{e_cx[31]}}, e_cx} + oxs);
          o_rz     <= pbo_pkg::sat32({{2{e_cz[31]}}, e_cz} - ozs);
          o_h      <= e_h;
          o_status <= e_status;
          o_last   <= e_last;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            unique case (job)
              J_PREV: begin
                if (cur_last) begin
                  job   <= J_LAST;
                  state <= S_LOAD;
                end else begin
                  state <= S_FIN;
                end
              end
              J_LAST: begin
                if (cur_closed) begin
                  job   <= J_FIRST;
                  state <= S_LOAD;
                end else begin
                  state <= S_FIN;
                end
              end
              J_FIRST: state <= S_FIN;
              J_SHORT: state <= S_IDLE;
            endcase
          end
        end
        S_FIN: begin
          if (cur_last) begin
            point_count <= '0;
          end else begin
            older_x  <= recent_x;
            older_z  <= recent_z;
            recent_x <= cur_x;
            recent_z <= cur_z;
            recent_h <= cur_y;
            if (point_count != pbo_pkg::MaxIndex) begin
              point_count <= point_count + 16'd1;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the block never takes a point while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("point taken while result pending");

  // too-short status always closes the path
  a_short_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == pbo_pkg::ST_SHORT) |-> (m_tlast && m_tdata == '0))
    else $error("bad too-short result");

  // normalization only runs on a nonzero direction
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_NORM) |-> (nx != '0 || nz != '0))
    else $error("normalize on zero vector");

  // a finished path leaves the point counter cleared
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && cur_last) |=> (point_count == '0))
    else $error("point count not cleared");

endmodule

`default_nettype wire
